// ----- rtl/core/pms_pkg.sv -----
package pms_pkg;

    // reading limits and widths
    localparam int RAW_W   = 10;
    localparam int VAL_W   = 8;
    localparam int TIME_W  = 48;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [RAW_W-1:0] RAW_MIN = RAW_W'(5);
    localparam logic [RAW_W-1:0] RAW_MAX = RAW_W'(200);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // samples per median window (odd, 3 to 7)
    localparam int WINDOW = 5;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int MID    = WINDOW / 2;

    localparam int STREAK_W = 8;
    localparam int JUMP_W   = 4;
    localparam logic [STREAK_W-1:0] STREAK_SAT = {STREAK_W{1'b1}};
    localparam logic [JUMP_W-1:0]   JUMP_SAT   = {JUMP_W{1'b1}};

    // register reset values
    localparam logic [7:0]  SPREAD_LIMIT_RST   = 8'd12;
    localparam logic [7:0]  STEP_LIMIT_RST     = 8'd30;
    localparam logic [3:0]  JUMP_CONFIRM_RST   = 4'd3;
    localparam logic [7:0]  LOCK_TOLERANCE_RST = 8'd3;
    localparam logic [7:0]  LOCK_COUNT_RST     = 8'd15;
    localparam logic [7:0]  FAIL_LIMIT_RST     = 8'd120;
    localparam logic [15:0] SHORT_IVL_RST      = 16'd600;
    localparam logic [15:0] LONG_IVL_RST       = 16'd4500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPREAD_LIMIT   = 3'd0,
        REG_STEP_LIMIT     = 3'd1,
        REG_JUMP_CONFIRM   = 3'd2,
        REG_LOCK_TOLERANCE = 3'd3,
        REG_LOCK_COUNT     = 3'd4,
        REG_FAIL_LIMIT     = 3'd5,
        REG_SHORT_IVL      = 3'd6,
        REG_LONG_IVL       = 3'd7
    } cfg_reg_t;

    function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        begin
            abs_diff = (a > b) ? (a - b) : (b - a);
        end
    endfunction

    // now + interval, saturating at the top of the time range
    function automatic logic [TIME_W-1:0] deadline(input logic [TIME_W-1:0] now,
                                                   input logic [CFG_W-1:0] ivl);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, now} + {{(TIME_W+1-CFG_W){1'b0}}, ivl};
            deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/ping_median_stabilizer.sv -----
// Latency reading stabiliser.
// Input stream s_axis_*: one beat per reading; tdata holds raw_ms in [9:0] and
// the millisecond timestamp now_ms in [57:10]. Output stream m_axis_*: exactly
// one beat per input beat, giving the state after that reading: shown_ms [7:0],
// shown_valid [8], is_locked [9].
// A beat accepted on s_axis goes first into the input register; then the full
// update (median-of-five rank network, spread check, smoothing or jump logic,
// 48-bit deadline add) feeds the result register that drives m_axis.
// Throughput is one beat per cycle unless m_axis stalls, set by that single update stage.
// If m_axis_tready is held low, the result register holds its beat and the
// input register can still take one more beat; after that s_axis_tready drops.
// Reset (rst_n low, asynchronous) clears lock, calibration, counters, deadline
// and shown value, and loads the register defaults. Window samples are not
// cleared; only entries written in the current window are used.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register per
// cycle. The user must write only while no beat is in flight; the block does not enforce it.
module ping_median_stabilizer
    import pms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // raw_ms[9:0], now_ms[57:10], zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // shown_ms[7:0], shown_valid[8], is_locked[9]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration
    logic [7:0]  spread_limit_reg, step_limit_reg, lock_tolerance_reg;
    logic [7:0]  lock_count_reg, fail_limit_reg;
    logic [3:0]  jump_confirm_reg;
    logic [15:0] short_ivl_reg, long_ivl_reg;

    // handshake and stage registers
    logic              in_valid_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_shown_reg;
    logic              out_shown_valid_reg;
    logic              out_locked_reg;

    // block state
    logic                lock_reg, lock_next;
    logic [VAL_W-1:0]    calib_value_reg, calib_value_next;
    logic [STREAK_W-1:0] calib_streak_reg, calib_streak_next;
    logic [STREAK_W-1:0] fail_streak_reg, fail_streak_next;
    logic [TIME_W-1:0]   next_due_reg, next_due_next;
    logic [CNT_W-1:0]    sample_count_reg, sample_count_next;
    logic [VAL_W-1:0]    shown_reg, shown_next;
    logic                shown_flag_reg, shown_flag_next;
    logic [VAL_W-1:0]    pending_reg, pending_next;
    logic [JUMP_W-1:0]   jump_streak_reg, jump_streak_next;
    logic [VAL_W-1:0]    samples_reg [WINDOW];

    logic out_free, advance;
    logic ok, due, window_done, sample_we;
    logic [VAL_W-1:0] raw8;
    logic [VAL_W-1:0] win [WINDOW];
    logic [CNT_W-1:0] rank [WINDOW];
    logic [VAL_W-1:0] med, win_max, win_min, spread;
    logic [STREAK_W-1:0] calib_inc, fail_inc;
    logic [JUMP_W-1:0]   jump_inc;
    logic [VAL_W+1:0]    smooth_sum;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_locked_reg, out_shown_valid_reg, out_shown_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_limit_reg   <= SPREAD_LIMIT_RST;
            step_limit_reg     <= STEP_LIMIT_RST;
            jump_confirm_reg   <= JUMP_CONFIRM_RST;
            lock_tolerance_reg <= LOCK_TOLERANCE_RST;
            lock_count_reg     <= LOCK_COUNT_RST;
            fail_limit_reg     <= FAIL_LIMIT_RST;
            short_ivl_reg      <= SHORT_IVL_RST;
            long_ivl_reg       <= LONG_IVL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPREAD_LIMIT:   spread_limit_reg   <= cfg_data[7:0];
                REG_STEP_LIMIT:     step_limit_reg     <= cfg_data[7:0];
                REG_JUMP_CONFIRM:   jump_confirm_reg   <= cfg_data[3:0];
                REG_LOCK_TOLERANCE: lock_tolerance_reg <= cfg_data[7:0];
                REG_LOCK_COUNT:     lock_count_reg     <= cfg_data[7:0];
                REG_FAIL_LIMIT:     fail_limit_reg     <= cfg_data[7:0];
                REG_SHORT_IVL:      short_ivl_reg      <= cfg_data;
                REG_LONG_IVL:       long_ivl_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            raw_reg <= s_axis_tdata[RAW_W-1:0];
            now_reg <= s_axis_tdata[RAW_W+TIME_W-1:RAW_W];
        end
    end

    // window view: the final sample of a window is the current reading
    assign raw8 = raw_reg[VAL_W-1:0];

    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            win[i] = (i == WINDOW - 1) ? raw8 : samples_reg[i];
        end
    end

    // rank of each sample, ties broken by position; the middle rank is the median
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i && ((win[j] < win[i]) || (win[j] == win[i] && j < i)))
                begin
                    rank[i] = rank[i] + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        med     = '0;
        win_max = win[0];
        win_min = win[0];
        for (int i = 0; i < WINDOW; i++)
        begin
            if (rank[i] == CNT_W'(MID))
            begin
                med = med | win[i];
            end
            if (win[i] > win_max)
            begin
                win_max = win[i];
            end
            if (win[i] < win_min)
            begin
                win_min = win[i];
            end
        end
    end

    assign spread = ((win_max - med) > (med - win_min)) ? (win_max - med) : (med - win_min);

    assign ok  = (raw_reg >= RAW_MIN) && (raw_reg <= RAW_MAX);
    assign due = (next_due_reg == '0) || (now_reg >= next_due_reg);
    assign window_done = (sample_count_reg == CNT_W'(WINDOW - 1));

    assign calib_inc = (calib_streak_reg == STREAK_SAT) ? calib_streak_reg
                                                        : calib_streak_reg + 1'b1;
    assign fail_inc  = (fail_streak_reg == STREAK_SAT) ? fail_streak_reg
                                                       : fail_streak_reg + 1'b1;
    assign jump_inc  = (jump_streak_reg == JUMP_SAT) ? jump_streak_reg
                                                     : jump_streak_reg + 1'b1;
    assign smooth_sum = {1'b0, shown_reg, 1'b0} + {2'b00, shown_reg} + {2'b00, med} + 10'd2;

    always_comb
    begin
        lock_next         = lock_reg;
        calib_value_next  = calib_value_reg;
        calib_streak_next = calib_streak_reg;
        fail_streak_next  = fail_streak_reg;
        next_due_next     = next_due_reg;
        sample_count_next = sample_count_reg;
        shown_next        = shown_reg;
        shown_flag_next   = shown_flag_reg;
        pending_next      = pending_reg;
        jump_streak_next  = jump_streak_reg;
        sample_we         = 1'b0;

        if (lock_reg)
        begin
            if (ok)
            begin
                fail_streak_next = '0;
                if (due)
                begin
                    if (window_done)
                    begin
                        sample_count_next = '0;
                        next_due_next     = deadline(now_reg, long_ivl_reg);
                        if (spread <= spread_limit_reg)
                        begin
                            if (!shown_flag_reg)
                            begin
                                shown_next      = med;
                                shown_flag_next = 1'b1;
                            end
                            else if (abs_diff(med, shown_reg) <= step_limit_reg)
                            begin
                                shown_next = smooth_sum[VAL_W+1:2];
                            end
                            else if (pending_reg != med)
                            begin
                                pending_next     = med;
                                jump_streak_next = JUMP_W'(1);
                            end
                            else
                            begin
                                jump_streak_next = jump_inc;
                                if (jump_inc >= jump_confirm_reg)
                                begin
                                    shown_next = med;
                                end
                            end
                        end
                    end
                    else
                    begin
                        sample_we         = 1'b1;
                        sample_count_next = sample_count_reg + 1'b1;
                        next_due_next     = deadline(now_reg, short_ivl_reg);
                    end
                end
            end
            else
            begin
                fail_streak_next = fail_inc;
                if (fail_inc >= fail_limit_reg)
                begin
                    lock_next         = 1'b0;
                    calib_value_next  = '0;
                    calib_streak_next = '0;
                    fail_streak_next  = '0;
                    sample_count_next = '0;
                    pending_next      = '0;
                    jump_streak_next  = '0;
                end
            end
        end
        else if (ok)
        begin
            if (calib_streak_reg != '0 &&
                abs_diff(raw8, calib_value_reg) <= lock_tolerance_reg)
            begin
                calib_streak_next = calib_inc;
            end
            else
            begin
                calib_value_next  = raw8;
                calib_streak_next = STREAK_W'(1);
            end
            if (calib_streak_next >= lock_count_reg)
            begin
                lock_next        = 1'b1;
                fail_streak_next = '0;
                if (!shown_flag_reg)
                begin
                    shown_next      = raw8;
                    shown_flag_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg         <= 1'b0;
            calib_value_reg  <= '0;
            calib_streak_reg <= '0;
            fail_streak_reg  <= '0;
            next_due_reg     <= '0;
            sample_count_reg <= '0;
            shown_reg        <= '0;
            shown_flag_reg   <= 1'b0;
            pending_reg      <= '0;
            jump_streak_reg  <= '0;
        end
        else if (advance)
        begin
            lock_reg         <= lock_next;
            calib_value_reg  <= calib_value_next;
            calib_streak_reg <= calib_streak_next;
            fail_streak_reg  <= fail_streak_next;
            next_due_reg     <= next_due_next;
            sample_count_reg <= sample_count_next;
            shown_reg        <= shown_next;
            shown_flag_reg   <= shown_flag_next;
            pending_reg      <= pending_next;
            jump_streak_reg  <= jump_streak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_we)
        begin
            samples_reg[sample_count_reg[IDX_W-1:0]] <= raw8;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_shown_reg       <= shown_next;
            out_shown_valid_reg <= shown_flag_next;
            out_locked_reg      <= lock_next;
        end
    end

endmodule
